### hw/rtl/lvf_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the sine table of the longitudinal force block.
// Used by the top level, the divider pipeline and the checker; depends on nothing.
package lvf_pkg;

    // Table steps per quarter wave.
    localparam int SINE_TABLE_DEPTH = 1024;

    localparam logic [63:0] INV_PI_Q32  = 64'd1367130551;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] SINE_DK     = 64'(SINE_TABLE_DEPTH) * INV_PI_Q32;

    localparam int SINE_W   = 17;
    localparam int IDX_W    = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int STEP_W   = $clog2(4 * SINE_TABLE_DEPTH) + 1;

    localparam int DIV_NUM_W = 48;
    localparam int DIV_DEN_W = 24;
    localparam int DIV_STEPS = DIV_NUM_W;

    localparam int FORCE_W = 48;
    localparam logic signed [63:0] FORCE_MAX = 64'sd140737488355327;
    localparam logic signed [63:0] FORCE_MIN = -64'sd140737488355328;

    typedef enum logic [1:0] {
        CFG_MASS    = 2'd0,
        CFG_GRAVITY = 2'd1,
        CFG_DRAG    = 2'd2,
        CFG_ROLL    = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic fault;
        logic drive_neg;
        logic brake_neg;
    } t_flags;

    typedef logic [SINE_W-1:0] t_sine_tab [0:SINE_TABLE_DEPTH];

    // Quarter-wave sine in Q1.16 from a thirteen-term Taylor series in Q2.30.
    function automatic t_sine_tab build_sine_tab();
        t_sine_tab   tab;
        logic [63:0] th;
        logic [63:0] th2;
        logic [63:0] term;
        longint      sum;
        longint      r;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
            th   = (64'(k) * HALF_PI_Q30 + 64'(SINE_TABLE_DEPTH / 2)) / 64'(SINE_TABLE_DEPTH);
            th2  = (th * th) >> 30;
            term = th;
            sum  = longint'(th);
            for (int n = 1; n <= 12; n++) begin
                term = ((term * th2) >> 30) / 64'((2 * n) * (2 * n + 1));
                if ((n % 2) == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            r = (sum + 8192) >>> 14;
            if (r > 65536) begin
                r = 65536;
            end
            tab[k] = SINE_W'(r);
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = build_sine_tab();

endpackage

### hw/rtl/lvf_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage.
// Depends on lvf_pkg for the operand widths.
module lvf_div import lvf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [DIV_NUM_W-1:0] i_num,
    input  logic [DIV_DEN_W-1:0] i_den,
    output logic [DIV_NUM_W-1:0] o_quo
);

    logic [DIV_DEN_W-1:0] r_rem [0:DIV_STEPS-1];
    logic [DIV_NUM_W-1:0] r_quo [0:DIV_STEPS-1];
    logic [DIV_DEN_W-1:0] r_den [0:DIV_STEPS-1];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [DIV_DEN_W-1:0] rem_in;
        logic [DIV_NUM_W-1:0] quo_in;
        logic [DIV_DEN_W-1:0] den_in;
        logic [DIV_DEN_W:0]   shifted;
        logic                 ge;
        logic [DIV_DEN_W-1:0] n_rem;

        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign quo_in = i_num;
            assign den_in = i_den;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign quo_in = r_quo[k-1];
            assign den_in = r_den[k-1];
        end

        // The remainder stays below the divisor, so it fits the divisor width.
        assign shifted = {rem_in, quo_in[DIV_NUM_W-1]};
        assign ge      = shifted >= {1'b0, den_in};
        assign n_rem   = ge ? DIV_DEN_W'(shifted - {1'b0, den_in}) : shifted[DIV_DEN_W-1:0];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_quo[k] <= {quo_in[DIV_NUM_W-2:0], ge};
                r_den[k] <= den_in;
            end
        end
    end

    assign o_quo = r_quo[DIV_STEPS-1];

endmodule

### hw/rtl/longitudinal_vehicle_force.sv
`timescale 1ns / 1ps
// Top level of the longitudinal force pipeline: five force terms, sum, saturation.
// Depends on lvf_pkg and lvf_div.
//
// Usage: each input item carries speed, drive and brake torque, wheel radius and
// road slope; each yields exactly one result item with the net force in Q40.8
// and two flags. Both channels use valid and stall. The block is stateless apart
// from four configuration registers (mass, gravity, drag and rolling constants),
// written through a valid/ready port that is always ready. Write them only while
// no item is in flight.
// An item passes DIV_STEPS + 2 = 50 register stages before its result shows on
// o_out_valid. One item is accepted every cycle unless a stalled result holds
// the pipeline; the length is set by the two torque dividers, which resolve one
// quotient bit per stage over a 48-bit numerator.
// Drag, rolling and grade terms take six stages (two multiply levels for drag and
// grade, one for rolling, sine read between), then a delay line for the quotients.
// When the receiver stalls a waiting result, the whole pipeline holds in place and
// o_in_stall rises in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits and sets the configuration registers to zero.
// A zero wheel radius drops both torque terms and sets radius_fault; a sum
// outside the 48-bit range clips to the nearest end and sets force_saturated.
module longitudinal_vehicle_force import lvf_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic signed [31:0]         i_speed,
    input  logic signed [31:0]         i_drive_torque,
    input  logic signed [31:0]         i_brake_torque,
    input  logic [23:0]                i_wheel_radius,
    input  logic signed [15:0]         i_road_slope,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [FORCE_W-1:0]  o_net_force,
    output logic                       o_force_saturated,
    output logic                       o_radius_fault,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [1:0]                 i_cfg_index,
    input  logic [31:0]                i_cfg_data
);

    localparam int LAT      = DIV_STEPS + 2;
    localparam int PART_DLY = DIV_STEPS - 4;
    localparam int FLG_DLY  = DIV_STEPS;
    localparam logic [STEP_W-1:0] D1 = STEP_W'(SINE_TABLE_DEPTH);
    localparam logic [STEP_W-1:0] D2 = STEP_W'(2 * SINE_TABLE_DEPTH);
    localparam logic [STEP_W-1:0] D3 = STEP_W'(3 * SINE_TABLE_DEPTH);

    logic en;
    logic r_valid [1:LAT];

    // Configuration registers.
    logic [31:0] r_mass;
    logic [23:0] r_gravity;
    logic [31:0] r_drag;
    logic [31:0] r_roll;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mass    <= '0;
            r_gravity <= '0;
            r_drag    <= '0;
            r_roll    <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_MASS:    r_mass    <= i_cfg_data;
                CFG_GRAVITY: r_gravity <= i_cfg_data[23:0];
                CFG_DRAG:    r_drag    <= i_cfg_data;
                CFG_ROLL:    r_roll    <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    // The pipeline moves as one unless the result register is full and stalled.
    assign en         = !(r_valid[LAT] && i_out_stall);
    assign o_in_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= LAT; k++) begin
                r_valid[k] <= 1'b0;
            end
        end else if (en) begin
            r_valid[1] <= i_in_valid;
            for (int k = 2; k <= LAT; k++) begin
                r_valid[k] <= r_valid[k-1];
            end
        end
    end

    // Stage 1: input capture.
    logic signed [31:0] r1_speed;
    logic signed [31:0] r1_drive;
    logic signed [31:0] r1_brake;
    logic [23:0]        r1_radius;
    logic signed [15:0] r1_slope;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_speed  <= i_speed;
            r1_drive  <= i_drive_torque;
            r1_brake  <= i_brake_torque;
            r1_radius <= i_wheel_radius;
            r1_slope  <= i_road_slope;
        end
    end

    // Magnitudes as unsigned values; the most negative input maps correctly.
    logic [31:0] av;
    logic [31:0] drive_mag;
    logic [31:0] brake_mag;
    logic [15:0] slope_mag;

    assign av        = r1_speed[31] ? (~r1_speed + 32'd1) : r1_speed;
    assign drive_mag = r1_drive[31] ? (~r1_drive + 32'd1) : r1_drive;
    assign brake_mag = r1_brake[31] ? (~r1_brake + 32'd1) : r1_brake;
    assign slope_mag = r1_slope[15] ? (~r1_slope + 16'd1) : r1_slope;

    // Torque terms: rounded quotient of |torque| * 2^16 by the radius.
    logic [DIV_NUM_W-1:0] drive_num;
    logic [DIV_NUM_W-1:0] brake_num;
    logic [DIV_NUM_W-1:0] drive_quo;
    logic [DIV_NUM_W-1:0] brake_quo;

    assign drive_num = {drive_mag, 16'd0} + DIV_NUM_W'(r1_radius >> 1);
    assign brake_num = {brake_mag, 16'd0} + DIV_NUM_W'(r1_radius >> 1);

    lvf_div u_div_drive (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (drive_num),
        .i_den (r1_radius),
        .o_quo (drive_quo)
    );

    lvf_div u_div_brake (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (brake_num),
        .i_den (r1_radius),
        .o_quo (brake_quo)
    );

    t_flags flags_in;
    t_flags r_flg [0:FLG_DLY-1];

    assign flags_in.fault     = (r1_radius == '0);
    assign flags_in.drive_neg = r1_drive[31];
    assign flags_in.brake_neg = r1_brake[31];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_flg[0] <= flags_in;
            for (int k = 1; k < FLG_DLY; k++) begin
                r_flg[k] <= r_flg[k-1];
            end
        end
    end

    // Stage 2: first multiply level.
    logic [63:0] r2_v2;
    logic [63:0] r2_rprod;
    logic [55:0] r2_mg;
    logic [63:0] r2_sprod;
    logic        r2_vneg;
    logic        r2_sneg;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_v2    <= 64'(av) * 64'(av);
            r2_rprod <= 64'(av) * 64'(r_roll);
            r2_mg    <= 56'(r_mass) * 56'(r_gravity);
            r2_sprod <= 64'(slope_mag) * SINE_DK;
            r2_vneg  <= r1_speed[31];
            r2_sneg  <= r1_slope[15];
        end
    end

    // Stage 3: drag partial products, rolling rounding, sine range reduction.
    // The largest slope is below 2.6 quarter waves, so no wrap is needed.
    logic [STEP_W-1:0] steps;
    logic [1:0]        quad;
    logic [STEP_W-1:0] qbase;
    logic [STEP_W-1:0] step_in;
    logic [IDX_W-1:0]  tab_idx;

    assign steps = STEP_W'((r2_sprod + (64'd1 << 43)) >> 44);

    always_comb begin
        if (steps >= D3) begin
            quad  = 2'd3;
            qbase = D3;
        end else if (steps >= D2) begin
            quad  = 2'd2;
            qbase = D2;
        end else if (steps >= D1) begin
            quad  = 2'd1;
            qbase = D1;
        end else begin
            quad  = 2'd0;
            qbase = '0;
        end
        step_in = steps - qbase;
        tab_idx = quad[0] ? IDX_W'(D1 - step_in) : IDX_W'(step_in);
    end

    logic [63:0]      r3_hi;
    logic [63:0]      r3_lo;
    logic [39:0]      r3_rmag;
    logic [IDX_W-1:0] r3_idx;
    logic             r3_sneg;
    logic             r3_vneg;
    logic [55:0]      r3_mg;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_hi   <= 64'(r2_v2[63:32]) * 64'(r_drag);
            r3_lo   <= 64'(r2_v2[31:0]) * 64'(r_drag);
            r3_rmag <= 40'((r2_rprod + (64'd1 << 23)) >> 24);
            r3_idx  <= tab_idx;
            r3_sneg <= quad[1] ^ r2_sneg;
            r3_vneg <= r2_vneg;
            r3_mg   <= r2_mg;
        end
    end

    // Stage 4: drag rounding and the sine table read.
    logic [55:0]       r4_dmag;
    logic [SINE_W-1:0] r4_smag;
    logic [39:0]       r4_rmag;
    logic              r4_vneg;
    logic              r4_sneg;
    logic [55:0]       r4_mg;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_dmag <= 56'((r3_hi + (r3_lo >> 32) + 64'd128) >> 8);
            r4_smag <= SINE_TAB[r3_idx];
            r4_rmag <= r3_rmag;
            r4_vneg <= r3_vneg;
            r4_sneg <= r3_sneg;
            r4_mg   <= r3_mg;
        end
    end

    // Stage 5: grade products and signed drag and rolling terms.
    // Both resist motion, so they take the sign opposite to the speed.
    logic [40:0]        r5_ghi;
    logic [48:0]        r5_glo;
    logic signed [63:0] r5_drag;
    logic signed [63:0] r5_roll;
    logic               r5_sneg;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_ghi  <= 41'(r4_mg[55:32]) * 41'(r4_smag);
            r5_glo  <= 49'(r4_mg[31:0]) * 49'(r4_smag);
            r5_drag <= r4_vneg ? $signed(64'(r4_dmag)) : -$signed(64'(r4_dmag));
            r5_roll <= r4_vneg ? $signed(64'(r4_rmag)) : -$signed(64'(r4_rmag));
            r5_sneg <= r4_sneg;
        end
    end

    // Stage 6: grade rounding and partial sum, then the wait for the quotients.
    logic [63:0]        gmag;
    logic signed [63:0] grav;
    logic signed [63:0] r_part [0:PART_DLY-1];

    assign gmag = 64'(r5_ghi) + ((64'(r5_glo) + (64'd1 << 31)) >> 32);
    assign grav = r5_sneg ? -$signed(gmag) : $signed(gmag);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_part[0] <= r5_drag + r5_roll + grav;
            for (int k = 1; k < PART_DLY; k++) begin
                r_part[k] <= r_part[k-1];
            end
        end
    end

    // Final stage: torque terms, total and saturation.
    t_flags             flg;
    logic signed [63:0] drive_term;
    logic signed [63:0] brake_term;
    logic signed [63:0] total;
    logic signed [63:0] n_force;
    logic               n_sat;

    assign flg        = r_flg[FLG_DLY-1];
    assign drive_term = flg.drive_neg ? -$signed(64'(drive_quo)) : $signed(64'(drive_quo));
    assign brake_term = flg.brake_neg ? -$signed(64'(brake_quo)) : $signed(64'(brake_quo));

    always_comb begin
        total = r_part[PART_DLY-1];
        if (!flg.fault) begin
            total = total + drive_term + brake_term;
        end
        if (total > FORCE_MAX) begin
            n_force = FORCE_MAX;
            n_sat   = 1'b1;
        end else if (total < FORCE_MIN) begin
            n_force = FORCE_MIN;
            n_sat   = 1'b1;
        end else begin
            n_force = total;
            n_sat   = 1'b0;
        end
    end

    logic signed [FORCE_W-1:0] r_out_force;
    logic                      r_out_sat;
    logic                      r_out_fault;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_force <= n_force[FORCE_W-1:0];
            r_out_sat   <= n_sat;
            r_out_fault <= flg.fault;
        end
    end

    assign o_out_valid       = r_valid[LAT];
    assign o_net_force       = r_out_force;
    assign o_force_saturated = r_out_sat;
    assign o_radius_fault    = r_out_fault;

endmodule

### hw/rtl/lvf_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the longitudinal force block, bound to the top level.
// Depends on lvf_pkg for the force width.
module lvf_chk import lvf_pkg::*; (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_stall,
    input logic signed [31:0]         i_speed,
    input logic signed [31:0]         i_drive_torque,
    input logic signed [31:0]         i_brake_torque,
    input logic [23:0]                i_wheel_radius,
    input logic signed [15:0]         i_road_slope,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input logic signed [FORCE_W-1:0]  o_net_force,
    input logic                       o_force_saturated,
    input logic                       o_radius_fault,
    input logic                       i_cfg_valid,
    input logic                       o_cfg_ready,
    input logic [1:0]                 i_cfg_index,
    input logic [31:0]                i_cfg_data
);

    // No result may appear in the cycle after reset.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // The input side only stalls when a result is waiting and held back.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a stalled result");

    // A clipped result sits at one end of the output range.
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_force_saturated) |->
            ((o_net_force == {1'b0, {(FORCE_W-1){1'b1}}}) ||
             (o_net_force == {1'b1, {(FORCE_W-1){1'b0}}})))
        else $error("saturated force not at a range limit");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_net_force) && $stable(o_force_saturated)
             && $stable(o_radius_fault)))
        else $error("stalled result changed");

endmodule

bind longitudinal_vehicle_force lvf_chk u_lvf_chk (.*);

### tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of the longitudinal force block: a directed table, then
// random items under random idling, checked against a table or a built-in predictor.
// Depends on lvf_pkg and the block longitudinal_vehicle_force.
module tb_top;
    import lvf_pkg::*;

    localparam int LATENCY     = DIV_STEPS + 2;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic signed [31:0] speed;
        logic signed [31:0] drive;
        logic signed [31:0] brake;
        logic [23:0]        radius;
        logic signed [15:0] slope;
    } t_item;

    typedef struct {
        logic signed [47:0] net;
        logic               sat;
        logic               fault;
    } t_force;

    // One directed row: an item and, where known at a glance, its result.
    typedef struct {
        t_item  item;
        bit     typed;
        t_force res;
    } t_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic signed [31:0] i_speed;
    logic signed [31:0] i_drive_torque;
    logic signed [31:0] i_brake_torque;
    logic [23:0]        i_wheel_radius;
    logic signed [15:0] i_road_slope;
    logic               o_out_valid;
    logic               i_out_stall;
    logic signed [47:0] o_net_force;
    logic               o_force_saturated;
    logic               o_radius_fault;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index;
    logic [31:0]        i_cfg_data;

    longitudinal_vehicle_force dut (.*);

    // Predictor copy of the configuration registers.
    logic [31:0] mass_q;
    logic [23:0] grav_q;
    logic [31:0] drag_q;
    logic [31:0] roll_q;

    logic [16:0] sine_rom [0:SINE_TABLE_DEPTH];
    t_force      pending_forces[$];
    int          fail_count;
    int          cycle_count;
    int          send_idle_pct;
    int          recv_idle_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Quarter-wave sine table, built from the Taylor series in Q2.30.
    function automatic void fill_sine_rom();
        logic [63:0] th;
        logic [63:0] th2;
        logic [63:0] term;
        longint      acc;
        longint      r;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
            th   = (64'(k) * 64'd1686629713 + 64'(SINE_TABLE_DEPTH / 2))
                   / 64'(SINE_TABLE_DEPTH);
            th2  = (th * th) >> 30;
            term = th;
            acc  = longint'(th);
            for (int n = 1; n <= 12; n++) begin
                term = ((term * th2) >> 30) / 64'((2 * n) * (2 * n + 1));
                acc  = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
            end
            if (acc < 0) acc = 0;
            r = (acc + 8192) >>> 14;
            if (r > 65536) r = 65536;
            sine_rom[k] = 17'(r);
        end
    endfunction

    // Signed sine of a Q3.13 angle in Q1.16.
    function automatic longint slope_sine(logic signed [15:0] a);
        logic [63:0]  mag;
        logic [127:0] prod;
        logic [63:0]  steps;
        logic [63:0]  rem;
        logic [63:0]  quad;
        logic [63:0]  idx;
        longint       v;
        mag   = (a < 0) ? 64'(-32'(a)) : 64'(a);
        prod  = 128'(mag) * 128'(SINE_TABLE_DEPTH) * 128'd1367130551 + (128'd1 << 43);
        steps = 64'(prod >> 44);
        rem   = steps % 64'(4 * SINE_TABLE_DEPTH);
        quad  = rem / SINE_TABLE_DEPTH;
        idx   = rem % SINE_TABLE_DEPTH;
        v     = quad[0] ? longint'(sine_rom[SINE_TABLE_DEPTH - idx]) : longint'(sine_rom[idx]);
        return ((quad >= 2) != (a < 0)) ? -v : v;
    endfunction

    // Torque divided by wheel radius, rounded half away from zero, signed Q.8.
    function automatic longint wheel_force(logic signed [31:0] t, logic [23:0] r);
        logic [63:0] mag;
        logic [63:0] q;
        mag = (t < 0) ? 64'(-64'(t)) : 64'(t);
        q   = ((mag << 16) + 64'(r / 2)) / 64'(r);
        return (t < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic t_force net_force_of(t_item it);
        logic [63:0]  av;
        logic [127:0] wide;
        logic [63:0]  mag;
        logic [63:0]  mg;
        longint       s;
        longint       total;
        t_force       res;
        av    = (it.speed < 0) ? 64'(-64'(it.speed)) : 64'(it.speed);
        // Quadratic drag: |v|^2 * drag >> 40, rounded.
        wide  = 128'(av * av) * 128'(drag_q);
        mag   = 64'((wide >> 32) + 128'd128 >> 8);
        total = (it.speed < 0) ? longint'(mag) : -longint'(mag);
        // Rolling resistance.
        mag   = (av * 64'(roll_q) + (64'd1 << 23)) >> 24;
        total += (it.speed < 0) ? longint'(mag) : -longint'(mag);
        // Grade term.
        s     = slope_sine(it.slope);
        mg    = 64'(mass_q) * 64'(grav_q);
        mag   = (mg >> 32) * 64'(s < 0 ? -s : s)
                + (((mg & 64'hFFFF_FFFF) * 64'(s < 0 ? -s : s) + (64'd1 << 31)) >> 32);
        total += (s < 0) ? -longint'(mag) : longint'(mag);
        res.fault = (it.radius == 0);
        if (!res.fault) total += wheel_force(it.drive, it.radius) + wheel_force(it.brake, it.radius);
        res.sat = 1'b0;
        if (total > FORCE_MAX) begin
            total   = FORCE_MAX;
            res.sat = 1'b1;
        end else if (total < FORCE_MIN) begin
            total   = FORCE_MIN;
            res.sat = 1'b1;
        end
        res.net = 48'(total);
        return res;
    endfunction

    // One register write; valid drops and the channel idles afterwards.
    task automatic write_reg(t_cfg_reg idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_MASS:    mass_q = data;
            CFG_GRAVITY: grav_q = data[23:0];
            CFG_DRAG:    drag_q = data;
            CFG_ROLL:    roll_q = data;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Stops sending and waits for the pipeline to drain so configuration is safe
    // to change.
    task automatic drain_pipeline();
        i_in_valid <= 1'b0;
        while (pending_forces.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // Sends one item, idling the sender at random before it; the expectation is
    // queued when the item is accepted. Valid stays high into the next item.
    task automatic send_item(t_item it, bit typed, t_force res);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_speed        <= it.speed;
        i_drive_torque <= it.drive;
        i_brake_torque <= it.brake;
        i_wheel_radius <= it.radius;
        i_road_slope   <= it.slope;
        do @(posedge i_clk); while (o_in_stall);
        pending_forces.push_back(typed ? res : net_force_of(it));
    endtask

    function automatic t_item random_item();
        t_item it;
        it.speed  = $urandom;
        it.drive  = $urandom;
        it.brake  = $urandom;
        it.radius = 24'($urandom);
        it.slope  = 16'($urandom);
        case ($urandom_range(5))
            0: it.speed  = $urandom_range(0, 40 << 16) - (20 << 16);
            1: it.radius = 0;
            2: it.radius = 24'($urandom_range(1, 255));
            3: it.slope  = 16'($urandom_range(0, 8192) - 4096);
            default: ;
        endcase
        return it;
    endfunction

    // Receiver: random stall, result checked against the oldest expectation.
    always @(posedge i_clk) begin
        t_force exp_res;
        if (i_rst_n) begin
            cycle_count <= cycle_count + 1;
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
            if (o_out_valid && !i_out_stall) begin
                if (pending_forces.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) $display("Unexpected result item, force %0d", o_net_force);
                end else begin
                    exp_res = pending_forces.pop_front();
                    if (exp_res.net !== o_net_force || exp_res.sat !== o_force_saturated
                            || exp_res.fault !== o_radius_fault) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("Mismatch: expected force %0d sat %0b fault %0b, got %0d %0b %0b",
                                     exp_res.net, exp_res.sat, exp_res.fault,
                                     o_net_force, o_force_saturated, o_radius_fault);
                    end
                end
            end
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    t_row table_rows[$];

    task automatic run_table();
        t_item it;
        t_force zero_res;
        zero_res = '{net: '0, sat: 1'b0, fault: 1'b0};
        // With all registers at zero only the torque terms act.
        it = '{speed: 32'sh7FFF_FFFF, drive: 0, brake: 0, radius: 24'd65536, slope: 16'sd100};
        table_rows.push_back('{it, 1'b1, zero_res});
        it = '{speed: 0, drive: 32'sd256, brake: 0, radius: 24'd65536, slope: 0};
        table_rows.push_back('{it, 1'b1, '{net: 48'sd256, sat: 1'b0, fault: 1'b0}});
        // A zero radius drops both torque terms and raises the fault flag.
        it = '{speed: 0, drive: 32'sh7FFF_FFFF, brake: -32'sh8000_0000, radius: 0, slope: 0};
        table_rows.push_back('{it, 1'b1, '{net: '0, sat: 1'b0, fault: 1'b1}});
        foreach (table_rows[i]) send_item(table_rows[i].item, table_rows[i].typed, table_rows[i].res);
        table_rows.delete();
        drain_pipeline();
        write_reg(CFG_MASS, 32'hFFFF_FFFF);
        write_reg(CFG_GRAVITY, 32'h00FF_FFFF);
        write_reg(CFG_DRAG, 32'hFFFF_FFFF);
        write_reg(CFG_ROLL, 32'hFFFF_FFFF);
        // Extremes under the largest constants: saturation both ways, sine quadrants.
        it = '{speed: -32'sh8000_0000, drive: -32'sh8000_0000, brake: -32'sh8000_0000,
               radius: 24'd1, slope: -16'sh8000};
        table_rows.push_back('{it, 1'b0, zero_res});
        it = '{speed: 32'sh7FFF_FFFF, drive: 32'sh7FFF_FFFF, brake: 32'sh7FFF_FFFF,
               radius: 24'd1, slope: 16'sh7FFF};
        table_rows.push_back('{it, 1'b0, zero_res});
        it = '{speed: -32'sh8000_0000, drive: 32'sh7FFF_FFFF, brake: 32'sh7FFF_FFFF,
               radius: 24'hFF_FFFF, slope: 16'sd12868};
        table_rows.push_back('{it, 1'b0, zero_res});
        it = '{speed: 32'sd65536, drive: -32'sd1000, brake: 32'sd77, radius: 24'hFF_FFFF,
               slope: -16'sd12868};
        table_rows.push_back('{it, 1'b0, zero_res});
        it = '{speed: 0, drive: 0, brake: 0, radius: 0, slope: 16'sd25736};
        table_rows.push_back('{it, 1'b0, zero_res});
        it = '{speed: -32'sd1, drive: 32'sd1, brake: -32'sd1, radius: 24'd3, slope: -16'sd1};
        table_rows.push_back('{it, 1'b0, zero_res});
        foreach (table_rows[i]) send_item(table_rows[i].item, table_rows[i].typed, table_rows[i].res);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_out_stall    = 1'b0;
        i_speed        = '0;
        i_drive_torque = '0;
        i_brake_torque = '0;
        i_wheel_radius = '0;
        i_road_slope   = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = CFG_MASS;
        i_cfg_data     = '0;
        mass_q = '0; grav_q = '0; drag_q = '0; roll_q = '0;
        fail_count = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        fill_sine_rom();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_table();
        // Random part in three idling phases, each with new register settings.
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 61 : 0;
            recv_idle_pct = (phase == 0) ? 61 : (phase == 1) ? 11 : 0;
            drain_pipeline();
            // Realistic mass, gravity and drag in the first phase, then random values.
            write_reg(CFG_MASS, phase == 0 ? 32'd1500 << 8 : $urandom);
            write_reg(CFG_GRAVITY, phase == 0 ? 32'd642908 : $urandom);
            write_reg(CFG_DRAG, phase == 0 ? 32'd26214 : $urandom);
            write_reg(CFG_ROLL, phase == 2 ? 32'd0 : $urandom_range(0, 1 << 20));
            for (int n = 0; n < 560; n++) begin
                t_force unused;
                unused = '{net: '0, sat: 1'b0, fault: 1'b0};
                send_item(random_item(), 1'b0, unused);
            end
        end
        drain_pipeline();
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
